FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the symbol packer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define SSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the symbol packer front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssp_pkg;

    // Input operations.
    typedef enum logic [1:0] {
        OP_GROUP  = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_END    = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WORD_BITS     = 2'd0,
        CFG_WIDE_ALPHABET = 2'd1,
        CFG_FIXED_LENGTH  = 2'd2,
        CFG_MULTIPLE_BASE = 2'd3
    } cfg_index_t;

    // Error codes carried on the result channel.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_COUNT  = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;
    localparam logic [31:0] COUNT_MAX = 32'h0000_ffff;
    localparam logic [6:0]  COUNT_LEN = 7'd16;

    // Kind of work handed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_ERROR = 2'd0,
        KIND_WORDS = 2'd1,
        KIND_SPLIT = 2'd2
    } desc_kind_t;

    // One queued work descriptor; it expands into one to five results.
    typedef struct packed {
        desc_kind_t  kind;
        logic [1:0]  err;
        logic        two_words;
        logic [63:0] word0;
        logic [63:0] word1;
        logic [6:0]  len0;
        logic [6:0]  len1;
        logic [4:0]  value;
        logic        wide;
        logic [2:0]  split_w;
        logic        pad_ones;
    } desc_t;

endpackage

FILE: rtl/core/ssp_fifo.sv
// ----------------------------------------------------------------------------
// ssp_fifo
// Short shifting queue of work descriptors between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ssp_pkg::desc_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output ssp_pkg::desc_t rd_data,
    output logic           empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    ssp_pkg::desc_t   mem_reg  [DEPTH];
    ssp_pkg::desc_t   mem_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] wr_idx;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[0];

    // The oldest entry always sits at the bottom; a pop shifts the rest down.
    assign wr_idx = rd_en ? (count_reg - CNT_W'(1)) : count_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            mem_next[i] = rd_en ? mem_reg[i + 1] : mem_reg[i];
        end
        mem_next[DEPTH - 1] = mem_reg[DEPTH - 1];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (wr_en && (CNT_W'(i) == wr_idx))
            begin
                mem_next[i] = wr_data;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            mem_reg[i] <= mem_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front
// Configuration registers, input acceptance, packing state and work descriptors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     opcode,
    input  logic [4:0]     symbol,
    input  logic [31:0]    group_count,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output logic           desc_push,
    output ssp_pkg::desc_t desc,
    input  logic           desc_full
);

    // Free bits after reset, for the reset width and alphabet.
    localparam logic [6:0] RESET_FREE = 7'd30;

    logic [6:0]  word_bits_reg;
    logic        wide_alphabet_reg;
    logic [7:0]  fixed_length_reg;
    logic [31:0] multiple_base_reg;

    logic [63:0] accum_reg, accum_next;
    logic [6:0]  free_reg, free_next;
    logic [7:0]  seen_reg, seen_next;
    logic        open_reg, open_next;

    logic        accept;
    logic [6:0]  w;
    logic [2:0]  s;
    logic [4:0]  smask;
    logic        fixed_mode;
    logic        splitting;
    logic [63:0] mask_w;
    logic [13:0] prod3;
    logic [14:0] prod5;
    logic [6:0]  q3;
    logic [4:0]  q5;
    logic [6:0]  cap;
    logic [63:0] start_accum;
    logic [6:0]  start_free;
    logic [63:0] a0, a1;
    logic [6:0]  f0, f1;
    logic [4:0]  sym_m, vplus, pv;
    logic        flush;
    logic [63:0] packed_accum;
    logic [6:0]  packed_free;
    logic [63:0] flush_word;
    logic [63:0] final_word;

    assign cfg_ready = 1'b1;
    assign full      = desc_full;
    assign accept    = push && !desc_full;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg     <= 7'd32;
            wide_alphabet_reg <= 1'b0;
            fixed_length_reg  <= 8'd0;
            multiple_base_reg <= 32'd1;
        end
        else if (cfg_valid)
        begin
            unique case (ssp_pkg::cfg_index_t'(cfg_index))
                ssp_pkg::CFG_WORD_BITS:     word_bits_reg     <= cfg_data[6:0];
                ssp_pkg::CFG_WIDE_ALPHABET: wide_alphabet_reg <= cfg_data[0];
                ssp_pkg::CFG_FIXED_LENGTH:  fixed_length_reg  <= cfg_data[7:0];
                ssp_pkg::CFG_MULTIPLE_BASE: multiple_base_reg <= cfg_data;
                default:                    word_bits_reg     <= word_bits_reg;
            endcase
        end
    end

    // Effective word width, symbol size and word masks.
    always_comb
    begin
        if (word_bits_reg == 7'd0)
        begin
            w = 7'd1;
        end
        else if (word_bits_reg > 7'd64)
        begin
            w = 7'd64;
        end
        else
        begin
            w = word_bits_reg;
        end
        s          = wide_alphabet_reg ? 3'd5 : 3'd3;
        smask      = wide_alphabet_reg ? 5'h1f : 5'h07;
        fixed_mode = (fixed_length_reg != 8'd0);
        splitting  = ({4'd0, s} > w);
        mask_w     = ssp_pkg::ALL_ONES >> (7'd64 - w);
    end

    // Whole symbols that fit a word: quotient by reciprocal multiplication.
    always_comb
    begin
        prod3 = 14'(w) * 14'd43;
        prod5 = 15'(w) * 15'd205;
        q3    = prod3[13:7];
        q5    = prod5[14:10];
        cap   = wide_alphabet_reg ? ({2'd0, q5} * 7'd5) : (q3 * 7'd3);
    end

    // Packing datapath: optional flush of the open word, then shift in.
    always_comb
    begin
        start_accum  = fixed_mode ? 64'd0 : ssp_pkg::ALL_ONES;
        start_free   = fixed_mode ? w : cap;
        a0           = open_reg ? accum_reg : start_accum;
        f0           = open_reg ? free_reg : start_free;
        sym_m        = symbol & smask;
        vplus        = (sym_m + 5'd1) & smask;
        if (opcode == ssp_pkg::OP_END)
        begin
            pv = 5'd0;
        end
        else
        begin
            pv = fixed_mode ? sym_m : vplus;
        end
        flush        = (f0 < {4'd0, s});
        a1           = flush ? start_accum : a0;
        f1           = flush ? start_free : f0;
        packed_accum = (a1 << s) | {59'd0, pv};
        packed_free  = f1 - {4'd0, s};
        flush_word   = a0 & mask_w;
        final_word   = packed_accum & mask_w;
    end

    // Item classification and descriptor build.
    always_comb
    begin
        accum_next      = accum_reg;
        free_next       = free_reg;
        seen_next       = seen_reg;
        open_next       = open_reg;
        desc_push       = 1'b0;
        desc            = '0;
        desc.kind       = ssp_pkg::KIND_WORDS;
        desc.err        = ssp_pkg::ERR_NONE;
        desc.len0       = w;
        desc.len1       = w;
        desc.wide       = wide_alphabet_reg;
        desc.split_w    = w[2:0];
        desc.pad_ones   = !fixed_mode;

        if (accept)
        begin
            unique case (opcode)
                ssp_pkg::OP_GROUP:
                begin
                    open_next = 1'b0;
                    seen_next = 8'd0;
                    if (group_count != multiple_base_reg)
                    begin
                        desc_push = 1'b1;
                        if (group_count > ssp_pkg::COUNT_MAX)
                        begin
                            desc.kind = ssp_pkg::KIND_ERROR;
                            desc.err  = ssp_pkg::ERR_COUNT;
                        end
                        else
                        begin
                            desc.word0     = mask_w;
                            desc.word1     = {48'd0, group_count[15:0]};
                            desc.len1      = ssp_pkg::COUNT_LEN;
                            desc.two_words = 1'b1;
                        end
                    end
                end
                ssp_pkg::OP_SYMBOL:
                begin
                    if (fixed_mode && (seen_reg >= fixed_length_reg))
                    begin
                        desc_push = 1'b1;
                        desc.kind = ssp_pkg::KIND_ERROR;
                        desc.err  = ssp_pkg::ERR_LENGTH;
                    end
                    else
                    begin
                        if (fixed_mode || (seen_reg != 8'hff))
                        begin
                            seen_next = seen_reg + 8'd1;
                        end
                        if (splitting)
                        begin
                            desc_push  = 1'b1;
                            desc.kind  = ssp_pkg::KIND_SPLIT;
                            desc.value = pv;
                        end
                        else
                        begin
                            accum_next = packed_accum;
                            free_next  = packed_free;
                            open_next  = 1'b1;
                            desc_push  = flush;
                            desc.word0 = flush_word;
                        end
                    end
                end
                ssp_pkg::OP_END:
                begin
                    open_next = 1'b0;
                    seen_next = 8'd0;
                    if (fixed_mode)
                    begin
                        if (seen_reg != fixed_length_reg)
                        begin
                            desc_push = 1'b1;
                            desc.kind = ssp_pkg::KIND_ERROR;
                            desc.err  = ssp_pkg::ERR_LENGTH;
                        end
                        else if (!splitting)
                        begin
                            desc_push  = 1'b1;
                            desc.word0 = flush_word;
                        end
                    end
                    else if (splitting)
                    begin
                        // Zero terminator split into padded pieces.
                        desc_push  = 1'b1;
                        desc.kind  = ssp_pkg::KIND_SPLIT;
                        desc.value = 5'd0;
                    end
                    else
                    begin
                        // Terminator packed, then the closing word.
                        desc_push = 1'b1;
                        if (flush)
                        begin
                            desc.word0     = flush_word;
                            desc.word1     = final_word;
                            desc.two_words = 1'b1;
                        end
                        else
                        begin
                            desc.word0 = final_word;
                        end
                    end
                end
                default:
                begin
                    desc_push = 1'b0;
                end
            endcase
        end
    end

    // Packing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= ssp_pkg::ALL_ONES;
            free_reg  <= RESET_FREE;
            seen_reg  <= 8'd0;
            open_reg  <= 1'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            free_reg  <= free_next;
            seen_reg  <= seen_next;
            open_reg  <= open_next;
        end
    end

endmodule

FILE: rtl/core/ssp_back.sv
// ----------------------------------------------------------------------------
// ssp_back
// Expands queued descriptors into result transfers, one result per cycle while pop is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ssp_pkg::desc_t fifo_data,
    input  logic           fifo_empty,
    output logic           fifo_pop,
    output logic           empty,
    input  logic           pop,
    output logic [63:0]    word,
    output logic [6:0]     word_len,
    output logic [1:0]     error,
    output logic           last
);

    ssp_pkg::desc_t cur_reg;
    logic           cur_valid_reg;
    logic           cur_valid_next;
    logic [2:0]     idx_reg;
    logic [2:0]     idx_next;

    logic [2:0]     s;
    logic [2:0]     q;
    logic [2:0]     r;
    logic [2:0]     n_pieces;
    logic [4:0]     mul;
    logic [4:0]     sh;
    logic [4:0]     mask_w;
    logic [4:0]     mask_r;
    logic [4:0]     piece;
    logic           advance;
    logic           last_piece;

    // Small lower-bit mask for widths up to four.
    function automatic logic [4:0] low_bits(input logic [2:0] n);
        return ~(5'h1f << n) & 5'h1f;
    endfunction

    // Full pieces of a symbol narrower words give.
    function automatic logic [2:0] split_count(input logic wide, input logic [2:0] w);
        logic [2:0] res;
        res = 3'd1;
        if (wide)
        begin
            if (w == 3'd1)
            begin
                res = 3'd5;
            end
            else if (w == 3'd2)
            begin
                res = 3'd2;
            end
        end
        else if (w == 3'd1)
        begin
            res = 3'd3;
        end
        return res;
    endfunction

    // Split geometry for the current descriptor.
    always_comb
    begin
        s      = cur_reg.wide ? 3'd5 : 3'd3;
        q      = split_count(cur_reg.wide, cur_reg.split_w);
        r      = 3'(s - 3'(q * cur_reg.split_w));
        mul    = 5'({2'd0, idx_reg} + 5'd1) * {2'd0, cur_reg.split_w};
        sh     = {2'd0, s} - mul;
        mask_w = low_bits(cur_reg.split_w);
        mask_r = low_bits(r);
        if (idx_reg < q)
        begin
            piece = (cur_reg.value >> sh) & mask_w;
        end
        else
        begin
            piece = (cur_reg.pad_ones ? (mask_w & ~mask_r) : 5'd0)
                  | (cur_reg.value & mask_r);
        end
    end

    // Result fields and piece count per descriptor kind.
    always_comb
    begin
        word     = 64'd0;
        word_len = 7'd1;
        error    = ssp_pkg::ERR_NONE;
        n_pieces = 3'd1;
        unique case (cur_reg.kind)
            ssp_pkg::KIND_ERROR:
            begin
                error = cur_reg.err;
            end
            ssp_pkg::KIND_WORDS:
            begin
                n_pieces = cur_reg.two_words ? 3'd2 : 3'd1;
                word     = (idx_reg == 3'd0) ? cur_reg.word0 : cur_reg.word1;
                word_len = (idx_reg == 3'd0) ? cur_reg.len0 : cur_reg.len1;
            end
            ssp_pkg::KIND_SPLIT:
            begin
                n_pieces = q + {2'd0, (r != 3'd0)};
                word     = {59'd0, piece};
                word_len = {4'd0, cur_reg.split_w};
            end
            default:
            begin
                n_pieces = 3'd1;
            end
        endcase
    end

    assign empty      = !cur_valid_reg;
    assign last_piece = (idx_reg == (n_pieces - 3'd1));
    assign last       = last_piece;
    assign advance    = pop && cur_valid_reg;
    assign fifo_pop   = (!cur_valid_reg || (advance && last_piece)) && !fifo_empty;

    // Walk through the pieces and load the next descriptor without a gap.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (fifo_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (advance && last_piece)
        begin
            cur_valid_next = 1'b0;
            idx_next       = 3'd0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop)
        begin
            cur_reg <= fifo_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

FILE: rtl/core/signature_symbol_packer.sv
// ----------------------------------------------------------------------------
// signature_symbol_packer
// Packs 3-bit or 5-bit signature symbols into words of 1 to 64 bits.
//
// Input items enter through a queue-like port: an item transfers on a clock
// edge with push high and full low. Results leave the same way: the oldest
// result is shown while empty is low and transfers when pop is high.
// Configuration registers are written through cfg_valid/cfg_ready with an
// index and data; ready is always high, and writes belong to idle periods.
// An input item can be taken every cycle while full is low. Its first result
// passes the queue and the result stage registers before it shows on the
// ports. Results leave at one per cycle, so split mode (word narrower than
// a symbol, up to five pieces per item) is paced by the result stage. A
// descriptor queue of QUEUE_DEPTH entries sits between the input side and the
// result stage; when the receiver stalls, results wait in place, the queue
// fills and full rises. Reset restores the register defaults (32-bit words,
// 3-bit symbols, variable length, base 1) and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signature_symbol_packer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [4:0]  symbol,
    input  logic [31:0] group_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] word,
    output logic [6:0]  word_len,
    output logic [1:0]  error,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ssp_pkg::desc_t front_desc;
    ssp_pkg::desc_t queue_head;
    logic           front_push;
    logic           queue_full;
    logic           queue_empty;
    logic           back_pop;

    // Front end: accepts and classifies items.
    ssp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .symbol      (symbol),
        .group_count (group_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .desc_push   (front_push),
        .desc        (front_desc),
        .desc_full   (queue_full)
    );

    // Descriptor queue between the two halves.
    ssp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_desc),
        .full    (queue_full),
        .rd_en   (back_pop),
        .rd_data (queue_head),
        .empty   (queue_empty)
    );

    // Back end: expands descriptors into results.
    ssp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_data  (queue_head),
        .fifo_empty (queue_empty),
        .fifo_pop   (back_pop),
        .empty      (empty),
        .pop        (pop),
        .word       (word),
        .word_len   (word_len),
        .error      (error),
        .last       (last)
    );

endmodule

FILE: rtl/core/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the result channel of the symbol packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] word,
    input logic [6:0]  word_len,
    input logic [1:0]  error,
    input logic        last
);

    // Error results carry no valid bits.
    `SSP_ASSERT_IMP(a_err_shape, clk, rst_n, !empty && (error != ssp_pkg::ERR_NONE), (word == 64'd0) && (word_len == 7'd1))

    // An error is always the only result of its item.
    `SSP_ASSERT_IMP(a_err_alone, clk, rst_n, !empty && (error != ssp_pkg::ERR_NONE), last)

    // Data results hold no bits above their length.
    `SSP_ASSERT_IMP(a_len_fit, clk, rst_n, !empty && (error == ssp_pkg::ERR_NONE), (word_len != 7'd0) && ((word >> word_len) == 64'd0))

    // A waiting result stays put until it is taken.
    `SSP_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(word) && $stable(last))

endmodule

bind signature_symbol_packer ssp_checker u_ssp_checker (.*);

FILE: sim/signature_symbol_packer_tb.sv
// ----------------------------------------------------------------------------
// signature_symbol_packer testbench
// Drives symbol, end-of-signature and group-start transfers into the packer
// and predicts every packed word, group header and error result. Both sides
// idle and stall at random, and the four registers are rewritten between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ssp_pkg::*;

// One packed word as it should leave the block.
typedef struct {
    logic [63:0] word;
    logic [6:0]  len;
    logic [1:0]  err;
    logic        last;
} packed_word_t;

// Predicts the packer's output and checks the words that it sends.
class packed_word_scoreboard;
    bit [6:0]     word_bits;
    bit           wide;
    bit [7:0]     fixed_len;
    bit [31:0]    base;
    bit [63:0]    accum;
    bit [7:0]     bits_free;
    bit [7:0]     symbols_seen;
    bit           word_open;
    packed_word_t expected_words[$];
    packed_word_t batch[$];
    int unsigned  mismatches;
    int unsigned  words_checked;

    function new();
        word_bits     = 7'd32;
        wide          = 1'b0;
        fixed_len     = 8'd0;
        base          = 32'd1;
        accum         = ALL_ONES;
        bits_free     = 8'd30;
        symbols_seen  = 8'd0;
        word_open     = 1'b0;
        mismatches    = 0;
        words_checked = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [31:0] data);
        case (idx)
            CFG_WORD_BITS:     word_bits = data[6:0];
            CFG_WIDE_ALPHABET: wide      = data[0];
            CFG_FIXED_LENGTH:  fixed_len = data[7:0];
            CFG_MULTIPLE_BASE: base      = data;
            default: ;
        endcase
    endfunction

    // A width of zero behaves as one, anything above 64 as 64.
    function int unsigned width_now();
        if (word_bits < 7'd1)
            return 1;
        if (word_bits > 7'd64)
            return 64;
        return word_bits;
    endfunction

    function int unsigned symbol_bits();
        return wide ? 5 : 3;
    endfunction

    function logic [63:0] low_mask(int unsigned n);
        if (n >= 64)
            return ALL_ONES;
        return (64'd1 << n) - 64'd1;
    endfunction

    function void emit(logic [63:0] w, int unsigned len, logic [1:0] err);
        batch.push_back('{word: w, len: 7'(len), err: err, last: 1'b0});
    endfunction

    // Fixed mode fills with zeros; variable mode fills with ones and only
    // uses a whole number of symbols per word.
    function void open_word();
        int unsigned w;
        w = width_now();
        if (fixed_len != 8'd0)
        begin
            accum     = 64'd0;
            bits_free = 8'(w);
        end
        else
        begin
            accum     = ALL_ONES;
            bits_free = 8'(w - w % symbol_bits());
        end
        word_open = 1'b1;
    endfunction

    function void pack_value(logic [63:0] v);
        int unsigned s;
        s = symbol_bits();
        if (!word_open)
            open_word();
        if (bits_free < s)
        begin
            emit(accum & low_mask(width_now()), width_now(), ERR_NONE);
            open_word();
        end
        accum     = (accum << s) | v;
        bits_free = bits_free - 8'(s);
    endfunction

    // Word narrower than a symbol: pieces most significant first, the short
    // final piece padded in its upper bits.
    function void split_value(logic [63:0] v, bit pad_ones);
        int unsigned s;
        int unsigned w;
        int unsigned r;
        logic [63:0] pad;
        s = symbol_bits();
        w = width_now();
        r = s % w;
        for (int unsigned k = 0; k < s / w; k++)
            emit((v >> (s - (k + 1) * w)) & low_mask(w), w, ERR_NONE);
        if (r != 0)
        begin
            pad = pad_ones ? (low_mask(w) & ~low_mask(r)) : 64'd0;
            emit(pad | (v & low_mask(r)), w, ERR_NONE);
        end
    endfunction

    // Works out the words caused by one accepted input transfer.
    function void note_item(logic [1:0] op, logic [4:0] sym_in, logic [31:0] cnt);
        int unsigned s;
        int unsigned w;
        logic [63:0] sym;
        logic [63:0] v;
        bit          splitting;
        s         = symbol_bits();
        w         = width_now();
        sym       = {59'd0, sym_in} & low_mask(s);
        splitting = s > w;
        batch.delete();
        case (op)
            OP_GROUP:
            begin
                word_open    = 1'b0;
                symbols_seen = 8'd0;
                if (cnt != base)
                begin
                    if (cnt > COUNT_MAX)
                        emit(64'd0, 1, ERR_COUNT);
                    else
                    begin
                        emit(low_mask(w), w, ERR_NONE);
                        emit({32'd0, cnt}, COUNT_LEN, ERR_NONE);
                    end
                end
            end
            OP_SYMBOL:
            begin
                if (fixed_len != 8'd0)
                begin
                    if (symbols_seen >= fixed_len)
                        emit(64'd0, 1, ERR_LENGTH);
                    else
                    begin
                        symbols_seen++;
                        if (splitting)
                            split_value(sym, 1'b0);
                        else
                            pack_value(sym);
                    end
                end
                else
                begin
                    v = (sym + 64'd1) & low_mask(s);
                    if (symbols_seen < 8'd255)
                        symbols_seen++;
                    if (splitting)
                        split_value(v, 1'b1);
                    else
                        pack_value(v);
                end
            end
            OP_END:
            begin
                if (fixed_len != 8'd0)
                begin
                    if (symbols_seen != fixed_len)
                        emit(64'd0, 1, ERR_LENGTH);
                    else if (!splitting)
                    begin
                        if (!word_open)
                            open_word();
                        emit(accum & low_mask(w), w, ERR_NONE);
                    end
                end
                else if (splitting)
                    split_value(64'd0, 1'b1);
                else
                begin
                    pack_value(64'd0);
                    emit(accum & low_mask(w), w, ERR_NONE);
                end
                word_open    = 1'b0;
                symbols_seen = 8'd0;
            end
            default: ;
        endcase
        if (batch.size() != 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_words.push_back(batch[i]);
    endfunction

    function void check_word(logic [63:0] word, logic [6:0] len, logic [1:0] err,
                             logic last);
        packed_word_t want;
        words_checked++;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected result: word %h, length %0d, error %0d, last %0b",
                     $time, word, len, err, last);
            mismatches++;
            return;
        end
        want = expected_words.pop_front();
        if (word !== want.word)
        begin
            $display("%0t: word expected %h, got %h", $time, want.word, word);
            mismatches++;
        end
        if (len !== want.len)
        begin
            $display("%0t: word_len expected %0d, got %0d", $time, want.len, len);
            mismatches++;
        end
        if (err !== want.err)
        begin
            $display("%0t: error expected %0d, got %0d", $time, want.err, err);
            mismatches++;
        end
        if (last !== want.last)
        begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, last);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_words.size();
    endfunction
endclass

module testbench;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 40;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [1:0]  opcode      = OP_GROUP;
    logic [4:0]  symbol      = 5'd0;
    logic [31:0] group_count = 32'd0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [63:0] word;
    logic [6:0]  word_len;
    logic [1:0]  error;
    logic        last;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_WORD_BITS;
    logic [31:0] cfg_data    = 32'd0;

    packed_word_scoreboard board = new();
    int unsigned cycles       = 0;
    int unsigned items_sent   = 0;
    int unsigned settings_run = 0;
    bit          quiet        = 1'b0;

    signature_symbol_packer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .symbol      (symbol),
        .group_count (group_count),
        .empty       (empty),
        .pop         (pop),
        .word        (word),
        .word_len    (word_len),
        .error       (error),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d words outstanding.",
                     cycles, board.outstanding());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Push is only lowered when a gap follows, so back-to-back transfers
    // keep it high.
    task automatic send_item(input logic [1:0] op, input logic [4:0] sym,
                             input logic [31:0] cnt);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        group_count <= cnt;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_item(op, sym, cnt);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Waits for every predicted word, then for transfers that produce none.
    task automatic drain_and_settle();
        push <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; only called while idle.
    task automatic write_settings(input logic [6:0] w, input bit wd,
                                  input logic [7:0] fixed, input logic [31:0] grp_base);
        cfg_index_t  idx[4];
        logic [31:0] val[4];
        idx = '{CFG_WORD_BITS, CFG_WIDE_ALPHABET, CFG_FIXED_LENGTH, CFG_MULTIPLE_BASE};
        val = '{{25'd0, w}, {31'd0, wd}, {24'd0, fixed}, grp_base};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [31:0] draw_count();
        case ($urandom_range(0, 5))
            0:       return board.base;
            1:       return $urandom_range(0, 3);
            2:       return COUNT_MAX;
            3:       return COUNT_MAX + 32'd1;
            4:       return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // A signature of mostly the right length, now and then one symbol off
    // or left without its end.
    task automatic send_signature();
        int unsigned n;
        if (board.fixed_len == 8'd0)
            n = $urandom_range(0, 8);
        else if (board.fixed_len == 8'd255)
            n = $urandom_range(0, 6);
        else
        begin
            n = board.fixed_len;
            case ($urandom_range(0, 5))
                0:       n = n + 1;
                1:       n = n - 1;
                default: ;
            endcase
        end
        for (int unsigned i = 0; i < n; i++)
            send_item(OP_SYMBOL, 5'($urandom), $urandom);
        if ($urandom_range(0, 9) != 0)
            send_item(OP_END, 5'($urandom), $urandom);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            case ($urandom_range(0, 9))
                0:       send_item(2'($urandom_range(0, 3)), 5'($urandom), $urandom);
                1:       send_item(OP_GROUP, 5'($urandom), draw_count());
                default: send_signature();
            endcase
        end
    endtask

    // Result side: random stalls, pop held high across back-to-back transfers.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            board.check_word(word, word_len, error, last);
        end
    end

    initial
    begin
        logic [6:0]  w;
        logic [7:0]  fixed;
        logic [31:0] grp_base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 32-bit words, 3-bit symbols, variable length, base 1.
        send_item(OP_GROUP, 5'd0, 32'd1);
        send_item(OP_GROUP, 5'd31, 32'd0);
        send_item(OP_GROUP, 5'd0, 32'h0000_ffff);
        send_item(OP_GROUP, 5'd0, 32'h0001_0000);
        send_item(OP_GROUP, 5'd0, 32'hffff_ffff);
        send_item(OP_SYMBOL, 5'd0, 32'd0);
        send_item(OP_SYMBOL, 5'd7, 32'd0);
        send_item(OP_SYMBOL, 5'd31, 32'hffff_ffff);
        send_item(OP_SYMBOL, 5'd5, 32'd0);
        send_item(OP_END, 5'd0, 32'd0);
        send_item(OP_UNUSED, 5'd31, 32'hffff_ffff);

        // Fixed length of three in 6-bit words: lazy flush, an excess
        // symbol, a group start that abandons a signature and a short end.
        drain_and_settle();
        write_settings(7'd6, 1'b0, 8'd3, 32'hffff_ffff);
        send_item(OP_SYMBOL, 5'd7, 32'd0);
        send_item(OP_SYMBOL, 5'd2, 32'd0);
        send_item(OP_SYMBOL, 5'd5, 32'd0);
        send_item(OP_SYMBOL, 5'd1, 32'd0);
        send_item(OP_END, 5'd0, 32'd0);
        send_item(OP_SYMBOL, 5'd3, 32'd0);
        send_item(OP_GROUP, 5'd0, 32'd2);
        send_item(OP_SYMBOL, 5'd6, 32'd0);
        send_item(OP_END, 5'd0, 32'd0);

        // One-bit words with 5-bit symbols: every symbol splits into pieces.
        drain_and_settle();
        write_settings(7'd1, 1'b1, 8'd0, 32'd0);
        send_item(OP_SYMBOL, 5'd31, 32'd0);
        send_item(OP_SYMBOL, 5'd21, 32'd0);
        send_item(OP_END, 5'd0, 32'd0);

        // Split mode with a fixed length: the end emits nothing.
        drain_and_settle();
        write_settings(7'd4, 1'b1, 8'd2, 32'd1);
        send_item(OP_SYMBOL, 5'd31, 32'd0);
        send_item(OP_SYMBOL, 5'd16, 32'd0);
        send_item(OP_END, 5'd0, 32'd0);

        // Random phases, the width extremes and out-of-range widths forced early.
        for (int unsigned p = 0; p < PHASES; p++)
        begin
            drain_and_settle();
            case (p)
                0:       w = 7'd1;
                1:       w = 7'd64;
                2:       w = 7'd0;
                3:       w = 7'd127;
                4:       w = 7'd4;
                default: w = 7'($urandom_range(1, 64));
            endcase
            if (p == 6)
                fixed = 8'd255;
            else
                fixed = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 6));
            case ($urandom_range(0, 3))
                0:       grp_base = 32'd0;
                1:       grp_base = 32'hffff_ffff;
                2:       grp_base = $urandom_range(0, 3);
                default: grp_base = $urandom;
            endcase
            quiet = (p % 3 == 2);
            write_settings(w, 1'($urandom_range(0, 1)), fixed, grp_base);
            random_phase(PHASE_ITEMS);
        end

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d input transfers under %0d register settings plus the reset values;",
                 items_sent, settings_run);
        $display("checked %0d packed words, headers and error results.", board.words_checked);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
